>>> rtl/io_latency_log2_histogram_top_macros.svh
// Assertion macros for the latency histogram block.
`ifndef IO_LATENCY_LOG2_HISTOGRAM_TOP_MACROS_SVH
`define IO_LATENCY_LOG2_HISTOGRAM_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ILH_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ILH_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ILH_ASSERT_IMPL(label, clk, rst_n, a, c)
`define ILH_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/ilh_pkg.sv
package ilh_pkg;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TS_W = 64;
  localparam int unsigned CNT_W = 64;
  localparam int unsigned LAT_W = 55;
  localparam int unsigned BKT_W = 5;
  localparam int unsigned ST_W = 3;

  typedef enum logic [1:0] {
    CMD_ISSUE = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [ST_W-1:0] ST_NEW = 3'd0;
  localparam logic [ST_W-1:0] ST_OVER = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_MATCH = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS = 3'd4;
  localparam logic [ST_W-1:0] ST_READ = 3'd5;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic scan_rd;    // issue table read at scan index
    logic scan_cmp;   // compare returned entry
    logic wr_entry;   // write key/start at slot
    logic set_valid;
    logic clr_valid;
    logic div_start;
    logic div_step;
    logic hist_rd;
    logic hist_wr;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_last;
    logic hit;
    logic div_done;
  } dp_sts_t;
endpackage

>>> rtl/ilh_ram.sv
module ilh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/ilh_ctrl.sv
`include "io_latency_log2_histogram_top_macros.svh"
module ilh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic [1:0]        in_cmd,
  output ilh_pkg::dp_cmd_t  cmd,
  input  ilh_pkg::dp_sts_t  sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WAIT, S_CMP, S_DIV, S_HRD, S_HWAIT, S_HWR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] op_r, op_nxt;

  // one item at a time; output register holds result while next item loads
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    op_nxt = op_r;
    cmd = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load = 1'b1;
          op_nxt = in_cmd;
          priority if (in_cmd == ilh_pkg::CMD_READ) begin
            state_nxt = S_HRD;
          end else if (in_cmd == ilh_pkg::CMD_NONE) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_CMP;
      S_CMP: begin
        cmd.scan_cmp = 1'b1;
        priority if (sts.hit) begin
          if (op_r == ilh_pkg::CMD_ISSUE) begin
            cmd.wr_entry = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.clr_valid = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else if (sts.scan_last) begin
          if (op_r == ilh_pkg::CMD_ISSUE) begin
            cmd.wr_entry = 1'b1;
            cmd.set_valid = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_HRD;
        end
      end
      S_HRD: begin
        cmd.hist_rd = 1'b1;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: state_nxt = (op_r == ilh_pkg::CMD_READ) ? S_DONE : S_HWR;
      S_HWR: begin
        cmd.hist_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r <= ilh_pkg::CMD_NONE;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r <= op_nxt;
    end
  end

  `ILH_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `ILH_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, !in_tready)
  `ILH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule

>>> rtl/ilh_dp.sv
`include "io_latency_log2_histogram_top_macros.svh"
module ilh_dp #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned BUCKETS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [135:0]      in_tdata,
  input  logic [1:0]        in_cmd,
  input  ilh_pkg::dp_cmd_t  cmd,
  output ilh_pkg::dp_sts_t  sts,
  output logic [127:0]      out_tdata
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW = $clog2(BUCKETS);
  // four 16-bit digits, reciprocal multiply then remainder for each
  localparam logic [6:0] DIV_STEPS = 7'd8;
  localparam logic [9:0] DIVISOR = 10'd1000;
  // ceil(2^36 / 1000): exact floor(v / 1000) for any 26-bit v
  localparam logic [26:0] DIV_RECIP = 27'd68719477;

  logic [1:0]  op_r;
  logic [63:0] key_r, now_r;
  logic [4:0]  idx_r;
  logic [CW-1:0] scan_r;
  logic [AW-1:0] free_r;
  logic        free_ok_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [AW-1:0] raddr, waddr;
  logic [AW-1:0] new_slot;
  logic        new_ok;
  logic [63:0] key_rd, start_rd;
  logic        hit;

  // divider: long division by 1000, one 16-bit digit at a time
  logic [63:0] quo_r;
  logic [63:0] num_r;
  logic [9:0]  rem_r;
  logic [15:0] qd_r;
  logic [6:0]  dcnt_r;
  logic [25:0] dv, qprod, dres;
  logic [52:0] dprod;

  logic [HW-1:0] hidx;
  logic [63:0] hist_rd;
  logic [BUCKETS-1:0] hvalid_r;
  logic [4:0] bucket_r;
  logic [63:0] cnt_new;
  logic [63:0] cnt_r;
  logic [63:0] count_o;
  logic [ilh_pkg::ST_W-1:0] status_r;
  logic [4:0] obucket_r;
  logic [63:0] ocount_r;
  logic [54:0] olat_r;
  logic [4:0] blen;

  assign raddr = scan_r[AW-1:0];
  assign hit = valid_r[raddr] && (key_rd == key_r);
  assign sts.hit = hit;
  assign sts.scan_last = (scan_r == CW'(TABLE_DEPTH - 1));
  assign sts.div_done = (dcnt_r == 7'd1);
  // lowest free slot, including the entry under compare on the last step
  assign new_ok = free_ok_r || !valid_r[raddr];
  assign new_slot = free_ok_r ? free_r : raddr;
  assign waddr = hit ? raddr : new_slot;

  ilh_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key (
    .clk, .we(cmd.wr_entry && !hit && new_ok), .waddr(waddr), .wdata(key_r),
    .raddr(raddr), .rdata(key_rd));
  ilh_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_start (
    .clk, .we(cmd.wr_entry && (hit || new_ok)), .waddr(waddr), .wdata(now_r),
    .raddr(raddr), .rdata(start_rd));

  assign dv = {rem_r, num_r[63:48]};
  assign dprod = {27'd0, dv} * {26'd0, DIV_RECIP};
  assign qprod = {10'd0, qd_r} * {16'd0, DIVISOR};
  assign dres = dv - qprod;

  // bit length of quotient, clamped
  always_comb begin
    blen = '0;
    for (int i = 0; i < 64; i++) begin
      if (quo_r[i]) begin
        blen = 5'((i + 1 < BUCKETS - 1) ? i + 1 : BUCKETS - 1);
      end
    end
  end

  assign hidx = (op_r == ilh_pkg::CMD_READ) ? HW'(idx_r) : HW'(blen);
  ilh_ram #(.WIDTH(64), .DEPTH(BUCKETS)) u_hist (
    .clk, .we(cmd.hist_wr), .waddr(bucket_r[HW-1:0]), .wdata(cnt_new),
    .raddr(hidx), .rdata(hist_rd));
  assign cnt_new = (hvalid_r[bucket_r[HW-1:0]] ? hist_rd : 64'd0) + 64'd1;

  assign count_o = (32'(idx_r) < BUCKETS && hvalid_r[idx_r[HW-1:0]]) ? hist_rd : 64'd0;

  logic st_set_r;
  logic [ilh_pkg::ST_W-1:0] st_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hvalid_r <= '0;
      dcnt_r <= '0;
      st_set_r <= 1'b0;
    end else begin
      if (cmd.set_valid && new_ok) valid_r[new_slot] <= 1'b1;
      if (cmd.clr_valid) valid_r[raddr] <= 1'b0;
      if (cmd.hist_wr) hvalid_r[bucket_r[HW-1:0]] <= 1'b1;
      if (cmd.div_start) dcnt_r <= DIV_STEPS;
      else if (cmd.div_step && dcnt_r != '0) dcnt_r <= dcnt_r - 7'd1;
      if (cmd.load) st_set_r <= 1'b0;
      else if (cmd.scan_cmp && (hit || sts.scan_last)) st_set_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_cmd;
      key_r <= {in_tdata[33:2], in_tdata[65:34]};
      now_r <= in_tdata[129:66];
      idx_r <= in_tdata[134:130];
      scan_r <= '0;
      free_ok_r <= 1'b0;
      free_r <= '0;
      quo_r <= '0;
    end
    if (cmd.scan_cmp) begin
      if (!valid_r[raddr] && !free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r <= raddr;
      end
      if (!hit) scan_r <= scan_r + CW'(1);
      if (hit || sts.scan_last) begin
        st_val_r <= (op_r == ilh_pkg::CMD_ISSUE)
          ? (hit ? ilh_pkg::ST_OVER : (new_ok ? ilh_pkg::ST_NEW : ilh_pkg::ST_FULL))
          : (hit ? ilh_pkg::ST_MATCH : ilh_pkg::ST_MISS);
      end
    end
    if (cmd.div_start) begin
      num_r <= now_r - start_rd;
      quo_r <= '0;
      rem_r <= '0;
    end else if (cmd.div_step && dcnt_r != '0) begin
      if (!dcnt_r[0]) begin
        // digit quotient by reciprocal multiply
        qd_r <= dprod[51:36];
      end else begin
        rem_r <= dres[9:0];
        quo_r <= {quo_r[47:0], qd_r};
        num_r <= {num_r[47:0], 16'd0};
      end
    end
    if (cmd.hist_rd) bucket_r <= (op_r == ilh_pkg::CMD_READ) ? idx_r : blen;
    if (cmd.hist_wr) cnt_r <= cnt_new;
    if (cmd.out_load) begin
      if (op_r == ilh_pkg::CMD_READ) begin
        status_r <= ilh_pkg::ST_READ;
        obucket_r <= idx_r;
        ocount_r <= count_o;
        olat_r <= '0;
      end else if (op_r == ilh_pkg::CMD_NONE || !st_set_r) begin
        status_r <= ilh_pkg::ST_MISS;
        obucket_r <= '0;
        ocount_r <= '0;
        olat_r <= '0;
      end else if (st_val_r == ilh_pkg::ST_MATCH) begin
        status_r <= ilh_pkg::ST_MATCH;
        obucket_r <= bucket_r;
        ocount_r <= cnt_r;
        olat_r <= quo_r[54:0];
      end else begin
        status_r <= st_val_r;
        obucket_r <= '0;
        ocount_r <= '0;
        olat_r <= '0;
      end
    end
  end

  // status|bucket|count|latency packed low to high
  assign out_tdata = {1'b0, olat_r, ocount_r, obucket_r, status_r};

  `ILH_ASSERT_IMPL(a_div_idle, clk, rst_n, cmd.scan_rd, dcnt_r == '0 || dcnt_r == 7'd1)
  `ILH_ASSERT_NEXT(a_clr, clk, rst_n, cmd.clr_valid, !valid_r[$past(raddr)])
  `ILH_ASSERT_IMPL(a_set_nohit, clk, rst_n, cmd.set_valid, !hit)
endmodule

>>> rtl/io_latency_log2_histogram_top.sv
// Block I/O latency histogram. Issue items (command 0) record a timestamp under
// key {device, sector_low}; complete items (command 1) free the entry, divide
// the elapsed nanoseconds by 1000 and bump the log2 bucket; command 2 reads a
// bucket. Every item yields one result. After acceptance a key search walks
// the table one entry at a time (read, wait for the memory, compare); a
// completion that matches then runs the divide (four 16-bit digits, reciprocal
// multiply then remainder) and the histogram read-modify-write before the
// result is loaded. A read goes straight to the histogram read. One item is
// processed at a time; the result register lets the next item start while a
// result waits.
module io_latency_log2_histogram_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned BUCKETS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[1:0], device[33:2], sector_low[65:34], timestamp_ns[129:66],
  // bucket_index[134:130]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], bucket[7:3], count[71:8], elapsed_us[126:72]
  output logic [127:0] out_tdata
);
  ilh_pkg::dp_cmd_t cmd;
  ilh_pkg::dp_sts_t sts;

  ilh_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .in_cmd(in_tdata[1:0]), .cmd, .sts);

  ilh_dp #(.TABLE_DEPTH(TABLE_DEPTH), .BUCKETS(BUCKETS)) u_dp (
    .clk, .rst_n, .in_tdata, .in_cmd(in_tdata[1:0]), .cmd, .sts, .out_tdata);
endmodule

>>> test/io_latency_log2_histogram_top_tb.sv
module io_latency_log2_histogram_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int NBKT = 24;
  localparam int N_RANDOM = 1350;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;

  always #5 clk = ~clk;

  io_latency_log2_histogram_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [54:0] lat;
    logic [63:0] cnt;
    logic [4:0]  bkt;
    logic [2:0]  st;
  } lat_result_t;

  typedef struct {
    ilh_pkg::cmd_t cmd;
    logic [31:0] dev;
    logic [31:0] sec;
    logic [63:0] ts;
    logic [4:0]  idx;
  } io_event_t;

  // directed table row; has_exp marks a hand-typed result
  typedef struct {
    io_event_t   ev;
    bit          has_exp;
    lat_result_t exp;
  } dir_row_t;

  // shadow of the block's table and histogram
  bit          tbl_valid[DEPTH];
  logic [63:0] tbl_key[DEPTH];
  logic [63:0] tbl_start[DEPTH];
  logic [63:0] hist[NBKT];

  lat_result_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  int rx_wait = 0;

  // keys issued so far, so completions mostly hit
  logic [63:0] live_keys[$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[io_latency_log2_histogram_top] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic lat_result_t predict_histogram(input io_event_t ev);
    lat_result_t r;
    logic [63:0] key, lat;
    int slot, len;
    r = '0;
    r.st = ilh_pkg::ST_MISS;
    key = {ev.dev, ev.sec};
    slot = -1;
    for (int i = 0; i < DEPTH; i++)
      if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
    case (ev.cmd)
      ilh_pkg::CMD_ISSUE: begin
        if (slot >= 0) begin
          tbl_start[slot] = ev.ts;
          r.st = ilh_pkg::ST_OVER;
        end else begin
          r.st = ilh_pkg::ST_FULL;
          for (int i = 0; i < DEPTH; i++)
            if (r.st == ilh_pkg::ST_FULL && !tbl_valid[i]) begin
              tbl_valid[i] = 1;
              tbl_key[i] = key;
              tbl_start[i] = ev.ts;
              r.st = ilh_pkg::ST_NEW;
            end
        end
      end
      ilh_pkg::CMD_COMPLETE: begin
        if (slot >= 0) begin
          lat = (ev.ts - tbl_start[slot]) / 64'd1000;
          len = 0;
          for (int b = 0; b < 64; b++) if (lat[b]) len = b + 1;
          if (len > NBKT - 1) len = NBKT - 1;
          tbl_valid[slot] = 0;
          hist[len] = hist[len] + 64'd1;
          r.st = ilh_pkg::ST_MATCH;
          r.bkt = len[4:0];
          r.cnt = hist[len];
          r.lat = lat[54:0];
        end
      end
      ilh_pkg::CMD_READ: begin
        r.st = ilh_pkg::ST_READ;
        r.bkt = ev.idx;
        r.cnt = (ev.idx < NBKT) ? hist[ev.idx] : 64'd0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one item; expectation queued at acceptance; valid stays up when
  // the next item follows with no idle cycle
  task automatic send_item(input io_event_t ev, input bit has_exp,
                           input lat_result_t exp);
    lat_result_t p;
    int w;
    w = $urandom_range(0, 18);
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tdata <= {1'b0, ev.idx, ev.ts, ev.sec, ev.dev, ev.cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    p = predict_histogram(ev);
    if (has_exp && p != exp)
      report_mismatch("directed row vs predictor", p[63:0], exp[63:0]);
    pending_results.push_back(p);
    if (ev.cmd == ilh_pkg::CMD_ISSUE && p.st == ilh_pkg::ST_NEW)
      live_keys.push_back({ev.dev, ev.sec});
  endtask

  function automatic io_event_t mk(ilh_pkg::cmd_t c, logic [31:0] d, logic [31:0] s,
                                   logic [63:0] t, logic [4:0] i);
    io_event_t e;
    e.cmd = c; e.dev = d; e.sec = s; e.ts = t; e.idx = i;
    return e;
  endfunction

  function automatic lat_result_t res(logic [2:0] st, logic [4:0] b,
                                      logic [63:0] c, logic [54:0] l);
    lat_result_t r;
    r.st = st; r.bkt = b; r.cnt = c; r.lat = l;
    return r;
  endfunction

  // receiver: compares each result against the oldest expectation, then draws
  // a random wait before taking the next
  always @(posedge clk) begin
    lat_result_t got, want;
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[126:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.st != want.st) report_mismatch("status", 64'(got.st), 64'(want.st));
          if (got.bkt != want.bkt) report_mismatch("bucket", 64'(got.bkt), 64'(want.bkt));
          if (got.cnt != want.cnt) report_mismatch("count", got.cnt, want.cnt);
          if (got.lat != want.lat)
            report_mismatch("elapsed_us", 64'(got.lat), 64'(want.lat));
        end
        w = $urandom_range(0, 18);
        rx_wait <= w;
        out_tready <= (w == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_tready <= (rx_wait == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t dir[$];
    io_event_t ev;
    lat_result_t none;
    logic [63:0] k, base;
    int r;
    none = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 0; tbl_key[i] = '0; tbl_start[i] = '0;
    end
    for (int i = 0; i < NBKT; i++) hist[i] = '0;

    // directed rows: reads after reset, extremes, miss, wrap, unused command
    dir.push_back('{mk(ilh_pkg::CMD_READ, '0, '0, '0, 5'd0), 1,
                    res(ilh_pkg::ST_READ, 5'd0, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_READ, '0, '0, '0, 5'd31), 1,
                    res(ilh_pkg::ST_READ, 5'd31, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_COMPLETE, 32'd1, 32'd2, 64'd3, 5'd0), 1,
                    res(ilh_pkg::ST_MISS, 5'd0, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_NONE, '1, '1, '1, '1), 1,
                    res(ilh_pkg::ST_MISS, 5'd0, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_ISSUE, '1, '1, '1, 5'd0), 1,
                    res(ilh_pkg::ST_NEW, 5'd0, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_ISSUE, '1, '1, 64'd5, 5'd0), 1,
                    res(ilh_pkg::ST_OVER, 5'd0, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_COMPLETE, '1, '1, 64'd999, 5'd0), 1,
                    res(ilh_pkg::ST_MATCH, 5'd0, 64'd1, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_ISSUE, '0, '0, '1, 5'd0), 0, none});
    // time went back
    dir.push_back('{mk(ilh_pkg::CMD_COMPLETE, '0, '0, 64'd2000, 5'd0), 0, none});
    dir.push_back('{mk(ilh_pkg::CMD_ISSUE, 32'd7, 32'd9, '0, 5'd0), 0, none});
    // top bucket
    dir.push_back('{mk(ilh_pkg::CMD_COMPLETE, 32'd7, 32'd9, '1, 5'd0), 0, none});
    dir.push_back('{mk(ilh_pkg::CMD_ISSUE, 32'd7, 32'd10, '0, 5'd0), 0, none});
    // bucket 1
    dir.push_back('{mk(ilh_pkg::CMD_COMPLETE, 32'd7, 32'd10, 64'd1000, 5'd0), 0, none});
    dir.push_back('{mk(ilh_pkg::CMD_READ, '0, '0, '0, 5'd23), 0, none});
    dir.push_back('{mk(ilh_pkg::CMD_READ, '0, '0, '0, 5'd24), 1,
                    res(ilh_pkg::ST_READ, 5'd24, '0, '0)});
    dir.push_back('{mk(ilh_pkg::CMD_READ, '0, '0, '0, 5'd1), 0, none});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_item(dir[i].ev, dir[i].has_exp, dir[i].exp);

    // fill the table to overflow, then drain
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(mk(ilh_pkg::CMD_ISSUE, 32'h100, i, 64'($urandom), 5'd0), 0, none);
    // hold off until the block has answered everything
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(mk(ilh_pkg::CMD_COMPLETE, 32'h100, i, {$urandom, $urandom}, 5'd0), 0, none);
    live_keys.delete();

    base = {$urandom, $urandom};
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      base = base + 64'($urandom_range(0, 1 << $urandom_range(0, 30)));
      if (r < 40) begin
        if ($urandom_range(0, 9) == 0)
          ev = mk(ilh_pkg::CMD_ISSUE, $urandom, $urandom, {$urandom, $urandom},
                  5'($urandom));
        else
          ev = mk(ilh_pkg::CMD_ISSUE, $urandom_range(0, 3), $urandom_range(0, 40), base,
                  5'($urandom));
      end else if (r < 80 && live_keys.size() > 0) begin
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        ev = mk(ilh_pkg::CMD_COMPLETE, k[63:32], k[31:0],
                ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : base, 5'($urandom));
      end else if (r < 85) begin
        ev = mk(ilh_pkg::CMD_COMPLETE, $urandom, $urandom, {$urandom, $urandom},
                5'($urandom));
      end else if (r < 97) begin
        ev = mk(ilh_pkg::CMD_READ, $urandom, $urandom, {$urandom, $urandom},
                5'($urandom_range(0, 31)));
      end else begin
        ev = mk(ilh_pkg::CMD_NONE, $urandom, $urandom, {$urandom, $urandom},
                5'($urandom));
      end
      send_item(ev, 0, none);
      if (live_keys.size() > 200) live_keys.delete();
    end
    in_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("[io_latency_log2_histogram_top] OK");
    end else begin
      $display("[io_latency_log2_histogram_top] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/ilh_pkg.sv
rtl/ilh_ram.sv
rtl/ilh_ctrl.sv
rtl/ilh_dp.sv
rtl/io_latency_log2_histogram_top.sv
test/io_latency_log2_histogram_top_tb.sv
